### rtl/rtpjb_pkg.sv
// ============================================================================
// rtpjb_pkg
// Shared types and constants for the RTP jitter buffer slot control.
// ============================================================================
package rtpjb_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int MAX_GAPS   = 32;
    localparam int GAP_AW     = $clog2(MAX_GAPS);
    localparam int REQ_PERIOD = 5;
    localparam int DEF_FILL   = 16;

    // action codes
    localparam logic [2:0] ACT_PUT   = 3'd0;
    localparam logic [2:0] ACT_TAKE  = 3'd1;
    localparam logic [2:0] ACT_FLUSH = 3'd2;
    localparam logic [2:0] ACT_TEAR  = 3'd3;

    typedef enum logic [2:0] {
        K_ACCEPT  = 3'd0,
        K_REJECT  = 3'd1,
        K_GAP     = 3'd2,
        K_TAKE_OK = 3'd3,
        K_SILENCE = 3'd4,
        K_NONE    = 3'd5,
        K_ACK     = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        ORD_EXPECTED = 3'd0,
        ORD_EARLY    = 3'd1,
        ORD_LATE     = 3'd2,
        ORD_DUP      = 3'd3,
        ORD_TOO_LATE = 3'd4
    } t_order;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_OK      = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PS_INIT     = 2'd0,
        PS_FILLING  = 2'd1,
        PS_READY    = 2'd2,
        PS_FLUSHING = 2'd3
    } t_play;

    typedef struct packed {
        logic [15:0] seq;
        t_status     status;
        logic        mark;
        logic [2:0]  phase;
    } t_slot;

    typedef struct packed {
        logic [15:0] start;
        logic [6:0]  count;
    } t_gap;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] seq_num;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [2:0]  order;
        logic [5:0]  slot;
        logic [15:0] gap_start;
        logic [6:0]  gap_count;
        logic [1:0]  buffer_state;
        logic        became_ready;
        logic [15:0] fill_level;
        logic        last;
    } t_out_item;

endpackage

### rtl/rtpjb_ram.sv
// ============================================================================
// rtpjb_ram
// Single-port synchronous RAM with registered read data.
// ============================================================================
module rtpjb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write, or read into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;
endmodule

### rtl/rtp_jitter_buffer_control.sv
// ============================================================================
// rtp_jitter_buffer_control
// Slot control of an RTP reorder buffer: classify puts, scan for gaps,
// release slots on take, flush and teardown, all over one slot RAM.
// ============================================================================
// Put: scans head to tail, steps the phase of each closed missing run,
//   classifies, marks skipped slots missing, then writes its own slot.
// Requests: one at a time; the single slot RAM port sets the pace, and
//   gap results wait while the output is stalled.
// Reset: synchronous active low; all slots read as free via valid bits.
module rtp_jitter_buffer_control (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rtpjb_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rtpjb_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [5:0]           i_cfg_data
);
    localparam int SW = rtpjb_pkg::SLOT_W;

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_SCAN_RD = 19'h00002,
        S_SCAN_PR = 19'h00004,
        S_PHS_RD  = 19'h00008,
        S_PHS_WR  = 19'h00010,
        S_CLS_RH  = 19'h00020,
        S_CLS_RT  = 19'h00040,
        S_CLS_EV  = 19'h00080,
        S_MRK_RD  = 19'h00100,
        S_MRK_WR  = 19'h00200,
        S_PUT_RD  = 19'h00400,
        S_PUT_WR  = 19'h00800,
        S_ACT_RD  = 19'h01000,
        S_ACT_WR  = 19'h02000,
        S_FIL_RH  = 19'h04000,
        S_FIL_RT  = 19'h08000,
        S_FIL_EV  = 19'h10000,
        S_GAP_RD  = 19'h20000,
        S_GAP_OUT = 19'h40000
    } t_seq_state;

    t_seq_state           r_state;
    logic                 r_fin;
    logic [2:0]           r_act;
    logic [15:0]          r_seq;
    logic [SW-1:0]        r_head, r_tail, r_addr, r_scan_i, r_rs;
    rtpjb_pkg::t_play     r_ps;
    logic [5:0]           r_dfill;
    logic [rtpjb_pkg::SLOTS-1:0] r_vld;
    logic                 r_rd_vld;
    rtpjb_pkg::t_slot     r_cur;
    logic                 r_have_cur, r_open;
    logic [SW:0]          r_len, r_k, r_m;
    logic [15:0]          r_rs_seq, r_hseq, r_fill;
    logic [2:0]           r_rs_ph;
    logic [rtpjb_pkg::GAP_AW:0] r_ngap, r_j;
    rtpjb_pkg::t_kind     r_kind;
    rtpjb_pkg::t_order    r_ord;
    logic [5:0]           r_slot;
    logic                 r_ready;
    logic                 r_ovld;
    rtpjb_pkg::t_out_item r_out;

    // RAM controls
    logic                 slot_we, slot_re;
    logic [SW-1:0]        slot_addr;
    rtpjb_pkg::t_slot     slot_wd, rdat;
    logic [$bits(rtpjb_pkg::t_slot)-1:0] slot_q;
    logic                 gap_we, gap_re;
    logic [rtpjb_pkg::GAP_AW-1:0] gap_addr;
    rtpjb_pkg::t_gap      gap_wd, gap_rd;
    logic [$bits(rtpjb_pkg::t_gap)-1:0] gap_q;

    // scan step terms
    logic                 c_open, c_close, c_rec;
    logic [SW-1:0]        c_rs, c_i1;
    logic [SW:0]          c_len;
    logic [15:0]          c_rs_seq;
    logic [2:0]           c_rs_ph;
    // classification terms
    logic signed [15:0]   c_fd, c_d;
    logic [15:0]          c_km1;
    logic [SW:0]          c_cap;
    rtpjb_pkg::t_order    c_ord;
    logic [SW-1:0]        c_sidx;
    logic [15:0]          c_fillv, c_mseq;
    logic                 out_free;
    logic                 c_emit;

    assign rdat     = r_rd_vld ? rtpjb_pkg::t_slot'(slot_q) : '0;
    assign gap_rd   = rtpjb_pkg::t_gap'(gap_q);
    assign c_sidx   = r_seq[SW-1:0];
    assign out_free = !r_ovld || i_out_ready;
    assign c_emit   = out_free && (r_fin || (r_state == S_GAP_OUT));
    assign o_in_ready  = (r_state == S_IDLE) && !r_fin;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

    // scan: open, extend and close missing runs
    always_comb begin
        c_open   = r_open || (r_cur.status == rtpjb_pkg::ST_MISSING);
        c_rs     = r_open ? r_rs : r_scan_i;
        c_len    = (r_open ? r_len : '0) + 1'b1;
        c_rs_seq = r_open ? r_rs_seq : r_cur.seq;
        c_rs_ph  = r_open ? r_rs_ph : r_cur.phase;
        c_close  = c_open && (rdat.status != rtpjb_pkg::ST_MISSING);
        c_rec    = c_close && (c_rs_ph == 3'd0)
                   && (r_ngap < (rtpjb_pkg::GAP_AW+1)'(rtpjb_pkg::MAX_GAPS));
        c_i1     = r_scan_i + 1'b1;
    end

    // classify a put against head and tail sequence numbers
    always_comb begin
        c_fd  = $signed(r_hseq - r_seq);
        c_d   = $signed(r_seq - rdat.seq);
        c_km1 = r_seq - rdat.seq - 16'd1;
        c_cap = (c_km1 > 16'(rtpjb_pkg::SLOTS)) ? (SW+1)'(rtpjb_pkg::SLOTS)
                                                 : c_km1[SW:0];
        if (r_ps == rtpjb_pkg::PS_INIT)       c_ord = rtpjb_pkg::ORD_EXPECTED;
        else if (c_fd > 16'sd0)               c_ord = rtpjb_pkg::ORD_TOO_LATE;
        else if (c_d == 16'sd1)               c_ord = rtpjb_pkg::ORD_EXPECTED;
        else if (c_d > 16'sd1)                c_ord = rtpjb_pkg::ORD_EARLY;
        else if (c_d == 16'sd0)               c_ord = rtpjb_pkg::ORD_DUP;
        else                                  c_ord = rtpjb_pkg::ORD_LATE;
        c_fillv = rdat.seq - r_hseq;
        c_mseq  = r_seq - 16'(r_m);
    end

    // slot RAM port
    always_comb begin
        slot_re   = 1'b0;
        slot_we   = 1'b0;
        slot_addr = r_addr;
        slot_wd   = rdat;
        case (r_state)
            S_SCAN_RD, S_PHS_RD, S_MRK_RD, S_PUT_RD, S_ACT_RD: slot_re = 1'b1;
            S_CLS_RH, S_FIL_RH: begin
                slot_re   = 1'b1;
                slot_addr = r_head;
            end
            S_CLS_RT, S_FIL_RT: begin
                slot_re   = 1'b1;
                slot_addr = r_tail;
            end
            S_PHS_WR: begin
                slot_we = 1'b1;
                slot_wd.phase = (rdat.phase >= 3'(rtpjb_pkg::REQ_PERIOD - 1))
                                ? 3'd0 : rdat.phase + 3'd1;
            end
            S_MRK_WR: begin
                slot_we = 1'b1;
                slot_wd.seq    = c_mseq;
                slot_wd.status = rtpjb_pkg::ST_MISSING;
            end
            S_PUT_WR: begin
                slot_we = 1'b1;
                slot_wd.seq    = r_seq;
                slot_wd.status = rtpjb_pkg::ST_OK;
            end
            S_ACT_WR: begin
                if (r_act == rtpjb_pkg::ACT_FLUSH) begin
                    slot_we = 1'b1;
                    slot_wd.seq  = r_seq;
                    slot_wd.mark = 1'b1;
                    if (rdat.status != rtpjb_pkg::ST_OK) begin
                        slot_wd.status = rtpjb_pkg::ST_MISSING;
                    end
                end else if (rdat.mark) begin
                    slot_we = 1'b1;
                    slot_wd.mark = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // gap list RAM port
    always_comb begin
        gap_we       = (r_state == S_SCAN_PR) && r_have_cur && c_rec;
        gap_re       = (r_state == S_GAP_RD);
        gap_addr     = gap_we ? r_ngap[rtpjb_pkg::GAP_AW-1:0]
                              : r_j[rtpjb_pkg::GAP_AW-1:0];
        gap_wd.start = c_rs_seq;
        gap_wd.count = 7'(c_len);
    end

    rtpjb_ram #(.WIDTH($bits(rtpjb_pkg::t_slot)), .DEPTH(rtpjb_pkg::SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_re    (slot_re),
        .i_addr  (slot_addr),
        .i_wdata (slot_wd),
        .o_rdata (slot_q)
    );

    rtpjb_ram #(.WIDTH($bits(rtpjb_pkg::t_gap)), .DEPTH(rtpjb_pkg::MAX_GAPS)) u_gap_ram (
        .i_clk   (i_clk),
        .i_we    (gap_we),
        .i_re    (gap_re),
        .i_addr  (gap_addr),
        .i_wdata (gap_wd),
        .o_rdata (gap_q)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= 1'b0;
            r_head  <= '0;
            r_tail  <= '0;
            r_ps    <= rtpjb_pkg::PS_INIT;
            r_dfill <= 6'(rtpjb_pkg::DEF_FILL);
            r_vld   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            // register write
            if (i_cfg_valid) begin
                r_dfill <= i_cfg_data;
            end
            if (slot_re) begin
                r_rd_vld <= r_vld[slot_addr];
            end
            if (slot_we) begin
                r_vld[slot_addr] <= 1'b1;
            end
            // load the next result, or drop the current one once taken
            if (c_emit) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end

            // emit the final result
            if (r_fin) begin
                if (out_free) begin
                    r_out <= '{result_kind: r_kind, order: r_ord, slot: r_slot,
                               gap_start: 16'd0, gap_count: 7'd0, buffer_state: r_ps,
                               became_ready: r_ready, fill_level: r_fill, last: 1'b1};
                    r_fin <= 1'b0;
                end
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (i_in_valid) begin
                            r_act   <= i_in_data.action;
                            r_seq   <= i_in_data.seq_num;
                            r_ngap  <= '0;
                            r_kind  <= rtpjb_pkg::K_ACK;
                            r_ord   <= rtpjb_pkg::ORD_EXPECTED;
                            r_slot  <= '0;
                            r_ready <= 1'b0;
                            r_state <= S_FIL_RH;
                            case (i_in_data.action)
                                rtpjb_pkg::ACT_PUT: begin
                                    r_open     <= 1'b0;
                                    r_have_cur <= 1'b0;
                                    if (r_head == r_tail) begin
                                        r_state <= S_CLS_RH;
                                    end else begin
                                        r_scan_i <= r_head;
                                        r_addr   <= r_head;
                                        r_state  <= S_SCAN_RD;
                                    end
                                end
                                rtpjb_pkg::ACT_TAKE: begin
                                    r_kind <= rtpjb_pkg::K_NONE;
                                    if (r_ps == rtpjb_pkg::PS_READY ||
                                        r_ps == rtpjb_pkg::PS_FLUSHING) begin
                                        r_addr  <= r_head;
                                        r_state <= S_ACT_RD;
                                    end
                                end
                                rtpjb_pkg::ACT_FLUSH: begin
                                    if (r_ps == rtpjb_pkg::PS_READY) begin
                                        r_addr  <= i_in_data.seq_num[SW-1:0];
                                        r_state <= S_ACT_RD;
                                    end
                                end
                                rtpjb_pkg::ACT_TEAR: begin
                                    r_vld  <= '0;
                                    r_head <= '0;
                                    r_tail <= '0;
                                    r_ps   <= rtpjb_pkg::PS_INIT;
                                end
                                default: ;
                            endcase
                        end
                    end
                    S_SCAN_RD: r_state <= S_SCAN_PR;
                    S_SCAN_PR: begin
                        r_cur <= rdat;
                        if (!r_have_cur) begin
                            r_have_cur <= 1'b1;
                            r_addr     <= c_i1;
                            r_state    <= S_SCAN_RD;
                        end else begin
                            r_scan_i <= c_i1;
                            r_rs     <= c_rs;
                            r_len    <= c_len;
                            r_rs_seq <= c_rs_seq;
                            r_rs_ph  <= c_rs_ph;
                            if (c_close) begin
                                r_open  <= 1'b0;
                                r_k     <= '0;
                                r_addr  <= c_rs;
                                r_state <= S_PHS_RD;
                                if (c_rec) begin
                                    r_ngap <= r_ngap + 1'b1;
                                end
                            end else begin
                                r_open <= c_open;
                                if (c_i1 == r_tail) begin
                                    r_state <= S_CLS_RH;
                                end else begin
                                    r_addr  <= c_i1 + 1'b1;
                                    r_state <= S_SCAN_RD;
                                end
                            end
                        end
                    end
                    S_PHS_RD: r_state <= S_PHS_WR;
                    S_PHS_WR: begin
                        r_k <= r_k + 1'b1;
                        if (r_k + 1'b1 == r_len) begin
                            if (r_scan_i == r_tail) begin
                                r_state <= S_CLS_RH;
                            end else begin
                                r_addr  <= r_scan_i + 1'b1;
                                r_state <= S_SCAN_RD;
                            end
                        end else begin
                            r_addr  <= r_rs + SW'(r_k + 1'b1);
                            r_state <= S_PHS_RD;
                        end
                    end
                    S_CLS_RH: r_state <= S_CLS_RT;
                    S_CLS_RT: begin
                        r_hseq  <= rdat.seq;
                        r_state <= S_CLS_EV;
                    end
                    S_CLS_EV: begin
                        r_ord <= c_ord;
                        if (r_ps == rtpjb_pkg::PS_INIT) begin
                            r_head <= c_sidx;
                        end
                        if (c_ord == rtpjb_pkg::ORD_DUP ||
                            c_ord == rtpjb_pkg::ORD_TOO_LATE) begin
                            r_kind  <= rtpjb_pkg::K_REJECT;
                            r_state <= S_FIL_RH;
                        end else begin
                            r_kind <= rtpjb_pkg::K_ACCEPT;
                            if (c_ord != rtpjb_pkg::ORD_LATE) begin
                                r_tail <= c_sidx;
                            end
                            if (r_ps == rtpjb_pkg::PS_INIT) begin
                                r_ps <= rtpjb_pkg::PS_FILLING;
                            end
                            if (c_ord == rtpjb_pkg::ORD_EARLY) begin
                                r_m     <= c_cap;
                                r_addr  <= SW'(r_seq - 16'(c_cap));
                                r_state <= S_MRK_RD;
                            end else begin
                                r_addr  <= c_sidx;
                                r_state <= S_PUT_RD;
                            end
                        end
                    end
                    S_MRK_RD: r_state <= S_MRK_WR;
                    S_MRK_WR: begin
                        if (r_m == (SW+1)'(1)) begin
                            r_addr  <= c_sidx;
                            r_state <= S_PUT_RD;
                        end else begin
                            r_m     <= r_m - 1'b1;
                            r_addr  <= SW'(c_mseq + 16'd1);
                            r_state <= S_MRK_RD;
                        end
                    end
                    S_PUT_RD: r_state <= S_PUT_WR;
                    S_PUT_WR: begin
                        r_slot  <= 6'(c_sidx);
                        r_state <= S_FIL_RH;
                    end
                    S_ACT_RD: r_state <= S_ACT_WR;
                    S_ACT_WR: begin
                        if (r_act == rtpjb_pkg::ACT_FLUSH) begin
                            r_ps <= rtpjb_pkg::PS_FLUSHING;
                        end else if (rdat.mark) begin
                            r_ps <= rtpjb_pkg::PS_FILLING;
                        end else if (rdat.status != rtpjb_pkg::ST_OK &&
                                     rdat.status != rtpjb_pkg::ST_MISSING) begin
                            r_ps <= rtpjb_pkg::PS_INIT;
                        end else begin
                            r_kind <= (rdat.status == rtpjb_pkg::ST_OK)
                                      ? rtpjb_pkg::K_TAKE_OK : rtpjb_pkg::K_SILENCE;
                            r_slot <= 6'(r_head);
                            r_vld[r_head] <= 1'b0;
                            if (r_head == r_tail) begin
                                r_ps <= rtpjb_pkg::PS_INIT;
                            end else begin
                                r_head <= r_head + 1'b1;
                            end
                        end
                        r_state <= S_FIL_RH;
                    end
                    S_FIL_RH: r_state <= S_FIL_RT;
                    S_FIL_RT: begin
                        r_hseq  <= rdat.seq;
                        r_state <= S_FIL_EV;
                    end
                    S_FIL_EV: begin
                        r_fill <= c_fillv;
                        if (r_act == rtpjb_pkg::ACT_PUT && r_kind == rtpjb_pkg::K_ACCEPT &&
                            r_ps == rtpjb_pkg::PS_FILLING && c_fillv >= 16'(r_dfill)) begin
                            r_ps    <= rtpjb_pkg::PS_READY;
                            r_ready <= 1'b1;
                        end
                        r_j <= '0;
                        if (r_ngap != '0) begin
                            r_state <= S_GAP_RD;
                        end else begin
                            r_fin   <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                    S_GAP_RD: r_state <= S_GAP_OUT;
                    S_GAP_OUT: begin
                        if (out_free) begin
                            r_out <= '{result_kind: rtpjb_pkg::K_GAP, order: 3'd0,
                                       slot: 6'd0, gap_start: gap_rd.start,
                                       gap_count: gap_rd.count, buffer_state: r_ps,
                                       became_ready: 1'b0, fill_level: r_fill,
                                       last: 1'b0};
                            r_j   <= r_j + 1'b1;
                            if (r_j + 1'b1 == r_ngap) begin
                                r_fin   <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_GAP_RD;
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end
endmodule

### rtl/rtpjb_checker.sv
// ============================================================================
// rtpjb_checker
// Port-level checks for the jitter buffer slot control.
// ============================================================================
module rtpjb_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input rtpjb_pkg::t_out_item o_out_data
);
    // hold a pending result until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // a gap request is never the final result of a request
    a_gap_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == rtpjb_pkg::K_GAP
        |-> !o_out_data.last && !o_out_data.became_ready)
        else $error("gap request marked last or ready");

    // stop taking requests after one is accepted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

    // ready returns only with the final result of the request in flight
    a_ready_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_ready) |-> o_out_valid && o_out_data.last)
        else $error("ready returned without final result");
endmodule

bind rtp_jitter_buffer_control rtpjb_checker u_rtpjb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### verif/rtp_jitter_buffer_control_tb.sv
// ----------------------------------------------------------------------------
// RTP jitter buffer slot control testbench
// Drives put, take, flush, teardown and tick requests through the valid/ready
// ports, predicts every result with a behavioral slot-ring model and compares
// each result field by field. Random idling on both sides, fill changes
// between phases, and a pause that lets the block drain completely.
// ----------------------------------------------------------------------------
module rtp_jitter_buffer_control_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = rtpjb_pkg::SLOTS;
    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] ACT_TICK = 3'd4;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    rtpjb_pkg::t_in_item  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    rtpjb_pkg::t_out_item o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [5:0]           i_cfg_data = '0;

    // slot ring model
    logic [15:0]        m_seq [NSLOT];
    rtpjb_pkg::t_status m_stat [NSLOT];
    logic               m_mark [NSLOT];
    logic [2:0]         m_phase [NSLOT];
    logic [5:0]         m_head, m_tail;
    rtpjb_pkg::t_play   m_play;
    logic [5:0]         m_fill_goal;

    rtpjb_pkg::t_out_item expected_q [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          requests_sent = 0;
    int          gaps_seen = 0;
    int          idle_cycles = 0;
    bit          no_idle = 1'b0;
    bit          done = 1'b0;
    logic [15:0] cur_seq;

    always #5 i_clk = ~i_clk;

    rtp_jitter_buffer_control u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic int signed seq_diff(logic [15:0] a, logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return d[15] ? int'(d) - 65536 : int'(d);
    endfunction

    function automatic void wipe_slot(int i);
        m_seq[i] = '0;
        m_stat[i] = rtpjb_pkg::ST_FREE;
        m_mark[i] = 1'b0;
        m_phase[i] = '0;
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < NSLOT; i++) wipe_slot(i);
        m_head = '0;
        m_tail = '0;
        m_play = rtpjb_pkg::PS_INIT;
        m_fill_goal = 6'(rtpjb_pkg::DEF_FILL);
    endfunction

    // Walk head..tail, request runs of missing slots, advance their phases.
    function automatic void scan_missing(ref rtpjb_pkg::t_out_item gaps [$]);
        bit                   open;
        int                   rs, len, nreq, nx, idx;
        rtpjb_pkg::t_out_item g;
        open = 0; rs = 0; len = 0; nreq = 0;
        for (int i = int'(m_head); i != int'(m_tail); i = (i + 1) % NSLOT) begin
            if (m_stat[i] == rtpjb_pkg::ST_MISSING && !open) begin
                open = 1; rs = i; len = 0;
            end
            if (open) len++;
            nx = (i + 1) % NSLOT;
            if (open && m_stat[nx] != rtpjb_pkg::ST_MISSING) begin
                if (m_phase[rs] == 0 && nreq < rtpjb_pkg::MAX_GAPS) begin
                    g = '0;
                    g.result_kind = rtpjb_pkg::K_GAP;
                    g.gap_start = m_seq[rs];
                    g.gap_count = 7'(len);
                    gaps.push_back(g);
                    nreq++;
                end
                for (int k = 0; k < len; k++) begin
                    idx = (rs + k) % NSLOT;
                    m_phase[idx] = 3'((int'(m_phase[idx]) + 1) % rtpjb_pkg::REQ_PERIOD);
                end
                open = 0;
            end
        end
    endfunction

    // Predict every result of one request and queue them in order.
    function automatic void predict_request(rtpjb_pkg::t_in_item it);
        rtpjb_pkg::t_out_item outs [$];
        rtpjb_pkg::t_out_item r;
        logic [5:0]  sidx;
        logic [15:0] fill, s;
        int          fd, d, k;
        r = '0;
        r.result_kind = rtpjb_pkg::K_ACK;
        sidx = it.seq_num[5:0];
        case (it.action)
            rtpjb_pkg::ACT_PUT: begin
                scan_missing(outs);
                if (m_play == rtpjb_pkg::PS_INIT) begin
                    m_head = sidx;
                    r.order = rtpjb_pkg::ORD_EXPECTED;
                end else begin
                    fd = seq_diff(m_seq[m_head], it.seq_num);
                    d = seq_diff(it.seq_num, m_seq[m_tail]);
                    if (fd > 0) r.order = rtpjb_pkg::ORD_TOO_LATE;
                    else if (d == 1) r.order = rtpjb_pkg::ORD_EXPECTED;
                    else if (d > 1) begin
                        k = (d - 1 > NSLOT) ? NSLOT : d - 1;
                        for (int m = k; m >= 1; m--) begin
                            s = it.seq_num - 16'(m);
                            m_stat[s[5:0]] = rtpjb_pkg::ST_MISSING;
                            m_seq[s[5:0]] = s;
                        end
                        r.order = rtpjb_pkg::ORD_EARLY;
                    end else if (d == 0) r.order = rtpjb_pkg::ORD_DUP;
                    else r.order = rtpjb_pkg::ORD_LATE;
                end
                if (r.order == rtpjb_pkg::ORD_DUP || r.order == rtpjb_pkg::ORD_TOO_LATE) begin
                    r.result_kind = rtpjb_pkg::K_REJECT;
                end else begin
                    r.result_kind = rtpjb_pkg::K_ACCEPT;
                    if (r.order != rtpjb_pkg::ORD_LATE) m_tail = sidx;
                    if (m_play == rtpjb_pkg::PS_INIT) m_play = rtpjb_pkg::PS_FILLING;
                    m_seq[sidx] = it.seq_num;
                    m_stat[sidx] = rtpjb_pkg::ST_OK;
                    r.slot = sidx;
                    fill = m_seq[m_tail] - m_seq[m_head];
                    if (m_play == rtpjb_pkg::PS_FILLING && fill >= 16'(m_fill_goal)) begin
                        m_play = rtpjb_pkg::PS_READY;
                        r.became_ready = 1'b1;
                    end
                end
            end
            rtpjb_pkg::ACT_TAKE: begin
                r.result_kind = rtpjb_pkg::K_NONE;
                if (m_play == rtpjb_pkg::PS_READY || m_play == rtpjb_pkg::PS_FLUSHING) begin
                    if (m_mark[m_head]) begin
                        m_play = rtpjb_pkg::PS_FILLING;
                        m_mark[m_head] = 1'b0;
                    end else if (m_stat[m_head] != rtpjb_pkg::ST_OK &&
                                 m_stat[m_head] != rtpjb_pkg::ST_MISSING) begin
                        m_play = rtpjb_pkg::PS_INIT;
                    end else begin
                        r.result_kind = (m_stat[m_head] == rtpjb_pkg::ST_OK)
                                        ? rtpjb_pkg::K_TAKE_OK : rtpjb_pkg::K_SILENCE;
                        r.slot = m_head;
                        k = m_head;
                        if (m_head == m_tail) m_play = rtpjb_pkg::PS_INIT;
                        else m_head = m_head + 6'd1;
                        wipe_slot(k);
                    end
                end
            end
            rtpjb_pkg::ACT_FLUSH: begin
                if (m_play == rtpjb_pkg::PS_READY) begin
                    m_play = rtpjb_pkg::PS_FLUSHING;
                    m_seq[sidx] = it.seq_num;
                    m_mark[sidx] = 1'b1;
                    if (m_stat[sidx] != rtpjb_pkg::ST_OK) m_stat[sidx] = rtpjb_pkg::ST_MISSING;
                end
            end
            rtpjb_pkg::ACT_TEAR: begin
                m_play = rtpjb_pkg::PS_INIT;
                m_head = '0;
                m_tail = '0;
                for (int i = 0; i < NSLOT; i++) wipe_slot(i);
            end
            default: ;
        endcase
        fill = m_seq[m_tail] - m_seq[m_head];
        outs.push_back(r);
        foreach (outs[i]) begin
            outs[i].buffer_state = m_play;
            outs[i].fill_level = fill;
            outs[i].last = (i == outs.size() - 1);
            expected_q.push_back(outs[i]);
        end
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Drop valid and idle for a random number of cycles.
    task automatic idle_gap();
        if (!no_idle && $urandom_range(99) < 14) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (!no_idle && $urandom_range(99) < 14);
        end
    endtask

    // Send one request; the model advances when it is accepted. Valid stays
    // high until the next request or a drain replaces or drops it.
    task automatic send_request(logic [2:0] act, logic [15:0] sn);
        rtpjb_pkg::t_in_item it;
        it.action = act;
        it.seq_num = sn;
        idle_gap();
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_request(it);
        requests_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Write the fill goal while the block is idle.
    task automatic write_fill_goal(logic [5:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        m_fill_goal = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Check each result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rtpjb_pkg::t_out_item w;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result kind", 16'(o_out_data.result_kind), 16'd0);
            end else begin
                w = expected_q.pop_front();
                if (w.result_kind == rtpjb_pkg::K_GAP) gaps_seen++;
                if (o_out_data.result_kind !== w.result_kind)
                    report_mismatch("result_kind", 16'(o_out_data.result_kind), 16'(w.result_kind));
                if (o_out_data.order !== w.order)
                    report_mismatch("order", 16'(o_out_data.order), 16'(w.order));
                if (o_out_data.slot !== w.slot)
                    report_mismatch("slot", 16'(o_out_data.slot), 16'(w.slot));
                if (o_out_data.gap_start !== w.gap_start)
                    report_mismatch("gap_start", o_out_data.gap_start, w.gap_start);
                if (o_out_data.gap_count !== w.gap_count)
                    report_mismatch("gap_count", 16'(o_out_data.gap_count), 16'(w.gap_count));
                if (o_out_data.buffer_state !== w.buffer_state)
                    report_mismatch("buffer_state", 16'(o_out_data.buffer_state),
                                    16'(w.buffer_state));
                if (o_out_data.became_ready !== w.became_ready)
                    report_mismatch("became_ready", 16'(o_out_data.became_ready),
                                    16'(w.became_ready));
                if (o_out_data.fill_level !== w.fill_level)
                    report_mismatch("fill_level", o_out_data.fill_level, w.fill_level);
                if (o_out_data.last !== w.last)
                    report_mismatch("last", 16'(o_out_data.last), 16'(w.last));
            end
        end
    end

    // Stall the result side at random.
    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(99) >= 14);
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || done || !i_rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_q.size());
            $display("== FAIL ==");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // Extremes of the sequence space, every action, init/tick/unused codes.
    task automatic test_directed();
        send_request(rtpjb_pkg::ACT_TAKE, 16'h0000);
        send_request(rtpjb_pkg::ACT_FLUSH, 16'hFFFF);
        send_request(ACT_TICK, 16'h1234);
        send_request(ACT_SPARE_LO, 16'hAAAA);
        send_request(ACT_SPARE_HI, 16'h5555);
        send_request(rtpjb_pkg::ACT_PUT, 16'hFFFE);
        send_request(rtpjb_pkg::ACT_PUT, 16'hFFFF);
        send_request(rtpjb_pkg::ACT_PUT, 16'h0000);
        send_request(rtpjb_pkg::ACT_PUT, 16'h0000);
        send_request(rtpjb_pkg::ACT_PUT, 16'h0005);
        send_request(rtpjb_pkg::ACT_PUT, 16'h0002);
        send_request(rtpjb_pkg::ACT_PUT, 16'hF000);
        send_request(rtpjb_pkg::ACT_PUT, 16'h0100);
        repeat (6) send_request(rtpjb_pkg::ACT_PUT, 16'h0101);
        send_request(rtpjb_pkg::ACT_TAKE, 16'h0);
        send_request(rtpjb_pkg::ACT_FLUSH, 16'h0110);
        send_request(rtpjb_pkg::ACT_TAKE, 16'h0);
        send_request(rtpjb_pkg::ACT_TAKE, 16'h0);
        send_request(rtpjb_pkg::ACT_TEAR, 16'hFFFF);
        send_request(rtpjb_pkg::ACT_TAKE, 16'h0);
    endtask

    // Many alternating short gaps: 31 single-slot runs in one scan.
    task automatic test_many_gaps();
        send_request(rtpjb_pkg::ACT_TEAR, 16'h0);
        cur_seq = 16'(($urandom_range(65535)));
        send_request(rtpjb_pkg::ACT_PUT, cur_seq);
        for (int i = 0; i < 31; i++) begin
            cur_seq = cur_seq + 16'd2;
            send_request(rtpjb_pkg::ACT_PUT, cur_seq);
        end
        repeat (12) send_request(rtpjb_pkg::ACT_PUT, cur_seq - 16'd1);
        send_request(rtpjb_pkg::ACT_TEAR, 16'h0);
    endtask

    // Stream mostly in order with reordering, loss, flushes and takes.
    task automatic test_stream(int n);
        int p;
        send_request(rtpjb_pkg::ACT_TEAR, 16'h0);
        cur_seq = 16'($urandom_range(65535));
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            if (p < 45) begin
                cur_seq = cur_seq + 16'd1;
                send_request(rtpjb_pkg::ACT_PUT, cur_seq);
            end else if (p < 55) begin
                cur_seq = cur_seq + 16'($urandom_range(2, 6));
                send_request(rtpjb_pkg::ACT_PUT, cur_seq);
            end else if (p < 62) begin
                send_request(rtpjb_pkg::ACT_PUT, cur_seq - 16'($urandom_range(0, 8)));
            end else if (p < 84) begin
                send_request(rtpjb_pkg::ACT_TAKE, 16'($urandom_range(65535)));
            end else if (p < 88) begin
                send_request(rtpjb_pkg::ACT_FLUSH, cur_seq + 16'($urandom_range(0, 3)));
            end else if (p < 90) begin
                cur_seq = cur_seq + 16'($urandom_range(60, 90));
                send_request(rtpjb_pkg::ACT_PUT, cur_seq);
            end else if (p < 93) begin
                send_request(ACT_TICK, 16'($urandom_range(65535)));
            end else if (p < 95) begin
                send_request(3'($urandom_range(int'(ACT_TICK), int'(ACT_SPARE_HI))),
                             16'($urandom_range(65535)));
            end else if (p < 97) begin
                send_request(rtpjb_pkg::ACT_PUT, 16'($urandom_range(65535)));
            end else if (p < 98) begin
                send_request(rtpjb_pkg::ACT_TEAR, 16'($urandom_range(65535)));
            end else begin
                send_request(rtpjb_pkg::ACT_PUT, cur_seq);
            end
        end
    endtask

    initial begin
        model_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_fill_goal(6'd1);
        test_many_gaps();
        test_stream(120);
        write_fill_goal(6'd32);
        test_stream(120);
        // drain fully, then a stretch with no idling
        wait_drained();
        no_idle = 1'b1;
        write_fill_goal(6'd0);
        test_stream(50);
        no_idle = 1'b0;
        write_fill_goal(6'd63);
        test_stream(30);
        write_fill_goal(6'd5);
        test_stream(35);
        wait_drained();
        done = 1'b1;
        $display("Sent %0d requests, checked %0d results including %0d gap requests,",
                 requests_sent, results_seen, gaps_seen);
        $display("over fill goals 1, 32, 0, 63, 5 with random stalls; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
